>>> rtl/strint_pkg.sv
`timescale 1ns / 1ps

package strint_pkg;

    // Width of the internal magnitude and of the character counters
    localparam int VALUE_BITS  = 64;
    localparam int OFFSET_BITS = 16;

    // Fixed widths of the ports
    localparam int OUT_VALUE_BITS  = 64;
    localparam int OUT_OFFSET_BITS = 16;
    localparam int CHAR_BITS       = 8;
    localparam int RADIX_BITS      = 6;
    localparam int DIGIT_BITS      = 6;

    // Product of magnitude and radix plus one digit
    localparam int MAC_BITS = VALUE_BITS + RADIX_BITS + 1;

    localparam logic [RADIX_BITS-1:0] RADIX_MAX  = 6'd36;
    localparam logic [RADIX_BITS-1:0] RADIX_HEX  = 6'd16;
    localparam logic [RADIX_BITS-1:0] RADIX_DEC  = 6'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_OCT  = 6'd8;
    localparam logic [RADIX_BITS-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RADIX_BITS-1:0] RADIX_ONE  = 6'd1;
    localparam logic [RADIX_BITS-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_BITS-1:0] BASE_RESET = 6'd10;

    localparam logic [DIGIT_BITS-1:0] NOT_DIGIT = 6'd63;

    // Character codes
    localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'd57;
    localparam logic [CHAR_BITS-1:0] CH_UPR_A = 8'd65;
    localparam logic [CHAR_BITS-1:0] CH_UPR_X = 8'd88;
    localparam logic [CHAR_BITS-1:0] CH_UPR_Z = 8'd90;
    localparam logic [CHAR_BITS-1:0] CH_LWR_A = 8'd97;
    localparam logic [CHAR_BITS-1:0] CH_LWR_X = 8'd120;
    localparam logic [CHAR_BITS-1:0] CH_LWR_Z = 8'd122;

    localparam logic [CHAR_BITS-1:0] UPR_OFFSET = 8'd55;
    localparam logic [CHAR_BITS-1:0] LWR_OFFSET = 8'd87;

    // Configuration register indexes
    localparam logic REG_NUMBER_BASE = 1'b0;

    typedef enum logic [2:0] {
        PH_SPACE   = 3'd0,
        PH_FIRST   = 3'd1,
        PH_ZERO    = 3'd2,
        PH_HEX     = 3'd3,
        PH_DIGITS  = 3'd4,
        PH_DONE    = 3'd5,
        PH_BADBASE = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_CONV  = 2'd1,
        ST_RANGE    = 2'd2,
        ST_BAD_BASE = 2'd3
    } status_t;

    typedef struct packed {
        phase_t                  phase;
        logic                    neg;
        logic [VALUE_BITS-1:0]   acc;
        logic                    ovf;
        logic [RADIX_BITS-1:0]   radix;
        logic [OFFSET_BITS-1:0]  pos;
        logic [OFFSET_BITS-1:0]  stop;
        logic                    seen;
    } parse_state_t;

    typedef struct packed {
        logic [OUT_VALUE_BITS-1:0]  value;
        logic [OUT_OFFSET_BITS-1:0] offset;
        status_t                    status;
    } parse_result_t;

    localparam parse_state_t STATE_RESET = '{
        phase: PH_SPACE,
        neg:   1'b0,
        acc:   '0,
        ovf:   1'b0,
        radix: RADIX_AUTO,
        pos:   '0,
        stop:  '0,
        seen:  1'b0
    };

    // Saturating increment of a character position
    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Digit value of a character, NOT_DIGIT for anything else
    function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
        logic [CHAR_BITS-1:0] d;
        d = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_UPR_A && c <= CH_UPR_Z) begin
            d = c - UPR_OFFSET;
        end else if (c >= CH_LWR_A && c <= CH_LWR_Z) begin
            d = c - LWR_OFFSET;
        end else begin
            return NOT_DIGIT;
        end
        return d[DIGIT_BITS-1:0];
    endfunction

endpackage

>>> rtl/string_to_signed_integer_parser_top.sv
`timescale 1ns / 1ps

// Streaming signed-integer parser: one byte of a NUL-terminated string per
// transfer, taking one character every clock cycle with no bubbles between
// strings. Each character is captured in an input register at its transfer,
// then combinational next-state logic, whose longest path is the 64x6
// multiply-add of the digit accumulator with its range compare, updates the
// parse state. A NUL's result lands in an output register at that same edge,
// so out_valid is registered, and the result transfers at an edge where
// out_stall is low. The input stalls only while a NUL reaches the parse
// logic and the previous result is still held by out_stall.
// number_base (APB offset 0) is sampled on the first character of a string;
// write it only between strings.
module string_to_signed_integer_parser_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // APB configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [2:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    // Character input
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [strint_pkg::CHAR_BITS-1:0]       char_code,
    // Result output
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [strint_pkg::OUT_VALUE_BITS-1:0] parsed_value,
    output logic [strint_pkg::OUT_OFFSET_BITS-1:0] end_offset,
    output logic [1:0]                             parse_status
);
    import strint_pkg::*;

    logic [RADIX_BITS-1:0] base_reg;
    logic                  cfg_write;

    logic                  ch_valid_reg;
    logic [CHAR_BITS-1:0]  ch_reg;
    logic                  advance;

    parse_state_t          state_reg;
    parse_state_t          state_next;
    parse_result_t         step_result;
    logic                  step_done;

    logic                  res_valid_reg;
    parse_result_t         res_reg;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_NUMBER_BASE);
    assign prdata    = (paddr[2] == REG_NUMBER_BASE) ? 32'(base_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            base_reg <= BASE_RESET;
        end else if (cfg_write) begin
            base_reg <= pwdata[RADIX_BITS-1:0];
        end
    end

    // Advance the held character unless it is a NUL whose result cannot be stored
    assign advance  = ch_valid_reg && (!step_done || !res_valid_reg || !out_stall);
    assign in_stall = ch_valid_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ch_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            ch_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            ch_reg <= char_code;
        end
    end

    strint_step u_step (
        .cur         (state_reg),
        .char_code   (ch_reg),
        .number_base (base_reg),
        .nxt         (state_next),
        .result      (step_result),
        .done        (step_done)
    );

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Output register: load on NUL, drop after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else if (advance && step_done) begin
            res_valid_reg <= 1'b1;
        end else if (res_valid_reg && !out_stall) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_done) begin
            res_reg <= step_result;
        end
    end

    assign out_valid    = res_valid_reg;
    assign parsed_value = $signed(res_reg.value);
    assign end_offset   = res_reg.offset;
    assign parse_status = res_reg.status;

endmodule

>>> rtl/strint_step.sv
`timescale 1ns / 1ps

// Next-state and result logic for one character of the string.
module strint_step (
    input  strint_pkg::parse_state_t             cur,
    input  logic [strint_pkg::CHAR_BITS-1:0]     char_code,
    input  logic [strint_pkg::RADIX_BITS-1:0]    number_base,
    output strint_pkg::parse_state_t             nxt,
    output strint_pkg::parse_result_t            result,
    output logic                                 done
);
    import strint_pkg::*;

    parse_state_t             s;
    logic [RADIX_BITS-1:0]    r_take;
    logic [DIGIT_BITS-1:0]    dig;
    logic                     dig_ok;
    logic [VALUE_BITS-1:0]    lim;
    logic [MAC_BITS-1:0]      mac;
    logic                     mac_ovf;
    logic [VALUE_BITS-1:0]    mag;
    logic [VALUE_BITS-1:0]    sval;
    logic [OFFSET_BITS+OUT_OFFSET_BITS-1:0] off_w;
    logic [OFFSET_BITS-1:0]   off;
    logic                     is_space;

    // Sample the base on the first character of a string
    always_comb
    begin
        s = cur;
        if (cur.phase == PH_SPACE && cur.pos == '0) begin
            s.radix = number_base;
            if (number_base == RADIX_ONE || number_base > RADIX_MAX) begin
                s.phase = PH_BADBASE;
            end
        end
    end

    // Shared multiply-add with overflow check against the signed limit
    always_comb
    begin
        r_take  = (s.radix == RADIX_AUTO) ? RADIX_DEC : s.radix;
        dig     = digit_of(char_code);
        dig_ok  = (dig < r_take) && (r_take >= RADIX_MIN);
        lim     = s.neg ? (VALUE_BITS'(1) << (VALUE_BITS - 1))
                        : ((VALUE_BITS'(1) << (VALUE_BITS - 1)) - 1'b1);
        mac     = MAC_BITS'(s.acc) * MAC_BITS'(r_take) + MAC_BITS'(dig);
        mac_ovf = mac > MAC_BITS'(lim);
    end

    // Advance the parse state
    always_comb
    begin
        nxt      = s;
        is_space = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
        done     = (char_code == CH_NUL);

        if (done) begin
            nxt = STATE_RESET;
        end else begin
            case (s.phase)
                PH_SPACE, PH_FIRST, PH_ZERO, PH_HEX, PH_DIGITS:
                begin
                    if (s.phase == PH_SPACE && is_space) begin
                        nxt.phase = PH_SPACE;
                    end else if (s.phase == PH_SPACE
                                 && (char_code == CH_PLUS || char_code == CH_MINUS)) begin
                        nxt.neg   = (char_code == CH_MINUS);
                        nxt.phase = PH_FIRST;
                    end else if ((s.phase == PH_SPACE || s.phase == PH_FIRST)
                                 && char_code == CH_ZERO) begin
                        // Leading zero: may open an octal or hex prefix
                        nxt.seen = 1'b1;
                        nxt.acc  = '0;
                        nxt.stop = sat_inc(s.pos);
                        if (s.radix == RADIX_AUTO) begin
                            nxt.radix = RADIX_OCT;
                            nxt.phase = PH_ZERO;
                        end else if (s.radix == RADIX_HEX) begin
                            nxt.phase = PH_ZERO;
                        end else begin
                            nxt.phase = PH_DIGITS;
                        end
                    end else if (s.phase == PH_ZERO
                                 && (char_code == CH_LWR_X || char_code == CH_UPR_X)) begin
                        // Stop position keeps pointing at the x
                        nxt.radix = RADIX_HEX;
                        nxt.seen  = 1'b0;
                        nxt.phase = PH_HEX;
                    end else begin
                        nxt.radix = r_take;
                        if (!dig_ok) begin
                            nxt.phase = PH_DONE;
                        end else begin
                            if (!s.ovf) begin
                                if (mac_ovf) begin
                                    nxt.ovf = 1'b1;
                                end else begin
                                    nxt.acc = mac[VALUE_BITS-1:0];
                                end
                            end
                            nxt.seen  = 1'b1;
                            nxt.stop  = sat_inc(s.pos);
                            nxt.phase = PH_DIGITS;
                        end
                    end
                end
                default:
                begin
                    nxt.phase = s.phase;
                end
            endcase
            nxt.pos = sat_inc(s.pos);
        end
    end

    // Build the result for the terminating NUL
    always_comb
    begin
        mag  = s.ovf ? lim : s.acc;
        sval = s.neg ? (VALUE_BITS'(0) - mag) : mag;
        off  = s.stop;
        result.value  = '0;
        result.status = ST_OK;
        if (s.phase == PH_BADBASE) begin
            result.status = ST_BAD_BASE;
            off           = '0;
        end else if (!s.seen) begin
            result.status = ST_NO_CONV;
        end else if (s.ovf) begin
            result.status = ST_RANGE;
            result.value  = OUT_VALUE_BITS'($signed(sval));
        end else begin
            result.value  = OUT_VALUE_BITS'($signed(sval));
        end
        off_w = (OFFSET_BITS + OUT_OFFSET_BITS)'(off);
        if (off_w > (OFFSET_BITS + OUT_OFFSET_BITS)'({OUT_OFFSET_BITS{1'b1}})) begin
            result.offset = {OUT_OFFSET_BITS{1'b1}};
        end else begin
            result.offset = off_w[OUT_OFFSET_BITS-1:0];
        end
    end

endmodule
